@@ rtl/assert_macros.svh @@
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CSMCF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CSMCF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/csmcf_pkg.sv @@
// shared types, codes and constants of the min cost flow solver
`timescale 1ns / 1ps
package csmcf_pkg;

  localparam int MAX_NODES_DEF = 64;
  localparam int MAX_ARCS_DEF  = 256;

  localparam int ALU_W  = 49;
  localparam int DIST_W = 32;
  localparam int EXC_W  = 24;
  localparam int FLOW_W = 24;
  localparam int COST_W = 47;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  localparam logic [1:0] REQ_SUPPLY = 2'd0;
  localparam logic [1:0] REQ_ARC    = 2'd1;
  localparam logic [1:0] REQ_SOLVE  = 2'd2;

  localparam logic REG_NODE_COUNT = 1'b0;
  localparam logic REG_ARC_COUNT  = 1'b1;

  localparam logic ALU_ADD = 1'b0;
  localparam logic ALU_SUB = 1'b1;

  typedef struct packed {
    logic [1:0]         req_type;
    logic [7:0]         item_index;
    logic signed [15:0] supply_value;
    logic [5:0]         arc_tail;
    logic [5:0]         arc_head;
    logic [15:0]        arc_weight;
  } in_req_t;

  typedef struct packed {
    logic              feasible;
    logic [COST_W-1:0] total_cost;
  } out_res_t;

  typedef struct packed {
    logic                    op;
    logic signed [ALU_W-1:0] a;
    logic signed [ALU_W-1:0] b;
  } alu_req_t;

endpackage

@@ rtl/csmcf_ram.sv @@
// single write port, single registered read port memory
`timescale 1ns / 1ps
module csmcf_ram import csmcf_pkg::*; #(
  parameter int DEPTH = 2,
  parameter int WIDTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/csmcf_alu.sv @@
// shared add, subtract and signed compare unit
`timescale 1ns / 1ps
module csmcf_alu import csmcf_pkg::*; (
  input  alu_req_t                req,
  output logic signed [ALU_W-1:0] res,
  output logic                    lt
);

  always_comb begin
    case (req.op)
      ALU_ADD: res = req.a + req.b;
      ALU_SUB: res = req.a - req.b;
      default: res = req.a;
    endcase
  end

  assign lt = (req.a < req.b);

endmodule

@@ rtl/capacity_scaling_min_cost_flow.sv @@
// capacity scaling min cost flow solver, top level with sequencer
//
// Supply and arc load requests are taken one per cycle while idle. A solve
// request keeps in_stall high until its result is registered: init reads and
// writes each node and clears each arc's flow, each scale phase scans excess
// node by node, and each augmentation runs an array Dijkstra of up to n
// rounds, each round a minimum scan over the nodes plus an arc sweep, followed
// by a potential update over the nodes and a walk along the path. The cost
// sum adds flow times weight over the arcs. One shared adder and comparator
// carries the wide adds, subtracts and distance compares; every store is a
// single-read memory with registered read data, which sets cycles per step.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module capacity_scaling_min_cost_flow import csmcf_pkg::*; #(
  parameter int MAX_NODES = MAX_NODES_DEF,
  parameter int MAX_ARCS  = MAX_ARCS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_req_t    in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_res_t   out_data,
  input  logic       cfg_we,
  input  logic       cfg_index,
  input  logic [8:0] cfg_wdata
);

  localparam int NAW = $clog2(MAX_NODES);
  localparam int NCW = $clog2(MAX_NODES + 1);
  localparam int AAW = (MAX_ARCS > 1) ? $clog2(MAX_ARCS) : 1;
  localparam int ACW = $clog2(MAX_ARCS + 1);
  localparam int PW  = AAW + 1;

  localparam logic [5:0] S_IDLE       = 6'd0;
  localparam logic [5:0] S_INIT       = 6'd1;
  localparam logic [5:0] S_INIT_RD    = 6'd2;
  localparam logic [5:0] S_INIT_WR    = 6'd3;
  localparam logic [5:0] S_FLOW_CLR   = 6'd4;
  localparam logic [5:0] S_SCALE      = 6'd5;
  localparam logic [5:0] S_FIND_START = 6'd6;
  localparam logic [5:0] S_FIND_RD    = 6'd7;
  localparam logic [5:0] S_FIND_CHK   = 6'd8;
  localparam logic [5:0] S_FIND_END   = 6'd9;
  localparam logic [5:0] S_SRCH_START = 6'd10;
  localparam logic [5:0] S_PICK_START = 6'd11;
  localparam logic [5:0] S_PICK_RD    = 6'd12;
  localparam logic [5:0] S_PICK_CHK   = 6'd13;
  localparam logic [5:0] S_PICK_END   = 6'd14;
  localparam logic [5:0] S_ARC_RD     = 6'd15;
  localparam logic [5:0] S_ARC_POT    = 6'd16;
  localparam logic [5:0] S_ARC_CHK    = 6'd17;
  localparam logic [5:0] S_ARC_RC1    = 6'd18;
  localparam logic [5:0] S_ARC_RC2    = 6'd19;
  localparam logic [5:0] S_ARC_ND     = 6'd20;
  localparam logic [5:0] S_ARC_CMP    = 6'd21;
  localparam logic [5:0] S_SRCH_END   = 6'd22;
  localparam logic [5:0] S_POT_RD     = 6'd23;
  localparam logic [5:0] S_POT_WR     = 6'd24;
  localparam logic [5:0] S_AUG_CHK    = 6'd25;
  localparam logic [5:0] S_AUG_PAR    = 6'd26;
  localparam logic [5:0] S_AUG_ARC    = 6'd27;
  localparam logic [5:0] S_EX_SRC_RD  = 6'd28;
  localparam logic [5:0] S_EX_SRC_WR  = 6'd29;
  localparam logic [5:0] S_EX_SNK_RD  = 6'd30;
  localparam logic [5:0] S_EX_SNK_WR  = 6'd31;
  localparam logic [5:0] S_COST_START = 6'd32;
  localparam logic [5:0] S_COST_RD    = 6'd33;
  localparam logic [5:0] S_COST_MUL   = 6'd34;
  localparam logic [5:0] S_COST_ACC   = 6'd35;
  localparam logic [5:0] S_DONE       = 6'd36;

  logic [5:0]  state_r;
  logic [6:0]  node_count_r;
  logic [8:0]  arc_count_r;
  logic [NCW-1:0] n_r, i_r, steps_r;
  logic [ACW-1:0] m_r, a_r;
  logic [15:0] top_r, scale_r;
  logic [NAW-1:0] src_r, snk_r, pick_r, tgt_r, cur_r;
  logic        src_ok_r, snk_ok_r, pick_ok_r, dir_r, feas_r;
  logic [MAX_NODES-1:0] reached_r, visited_r, pvalid_r;
  logic signed [DIST_W-1:0] best_r, dc_r, nd_r;
  logic [5:0]  at_r, ah_r;
  logic [15:0] aw_r;
  logic [FLOW_W-1:0] af_r;
  logic signed [ALU_W-1:0] tmp_r;
  logic [PW-1:0] par_r;
  logic [39:0] prod_r;
  logic [COST_W-1:0] total_r;
  logic        out_valid_r;
  out_res_t    out_res_r;

  // memory ports
  logic [NAW-1:0] nra, pra_t, pra_h;
  logic [AAW-1:0] ara;
  logic [15:0] sup_q;
  logic [EXC_W-1:0] ex_q;
  logic [DIST_W-1:0] pt_q, ph_q, dist_q;
  logic [PW-1:0] par_q;
  logic [5:0] t_q, h_q;
  logic [15:0] w_q;
  logic [FLOW_W-1:0] flow_q;

  logic sup_we, arc_we, ex_we, pot_we, dist_we, par_we, flow_we;
  logic [NAW-1:0] ex_wa, pot_wa, dist_wa;
  logic [AAW-1:0] flow_wa;
  logic [EXC_W-1:0] ex_wd;
  logic [DIST_W-1:0] pot_wd, dist_wd;
  logic [FLOW_W-1:0] flow_wd;

  alu_req_t alu_req;
  logic signed [ALU_W-1:0] alu_res;
  logic alu_lt;

  logic in_acc;
  logic last_node, last_arc;
  logic signed [31:0] ex_s, scale_s;
  logic src_hit, snk_hit;
  logic arc_ok, fwd, rev;
  logic relax_upd;
  logic [15:0] sup_abs;
  logic [ALU_W-1:0] cost_sum;

  function automatic logic [NAW-1:0] dc_node();
    return pick_r;
  endfunction

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_res_r;

  assign last_node = ((i_r + NCW'(1)) == n_r);
  assign last_arc  = ((a_r + ACW'(1)) == m_r);

  assign ex_s    = 32'($signed(ex_q));
  assign scale_s = 32'(scale_r);
  assign src_hit = (ex_s >= scale_s);
  assign snk_hit = (ex_s <= -scale_s);

  assign arc_ok = (32'(at_r) < 32'(n_r)) && (32'(ah_r) < 32'(n_r));
  assign fwd = arc_ok && (32'(at_r) == 32'(dc_node())) && !visited_r[NAW'(ah_r)];
  assign rev = arc_ok && (32'(ah_r) == 32'(dc_node())) && (af_r != '0)
               && !visited_r[NAW'(at_r)];
  assign relax_upd = !reached_r[tgt_r] || alu_lt;

  assign sup_abs = sup_q[15] ? (16'd0 - sup_q) : sup_q;
  assign cost_sum = alu_res;

  // memory addressing and shared unit operands
  always_comb begin
    nra = i_r[NAW-1:0];
    pra_t = NAW'(at_r);
    pra_h = NAW'(ah_r);
    ara = a_r[AAW-1:0];
    ex_we = 1'b0;
    ex_wa = i_r[NAW-1:0];
    ex_wd = alu_res[EXC_W-1:0];
    pot_we = 1'b0;
    pot_wa = i_r[NAW-1:0];
    pot_wd = alu_res[DIST_W-1:0];
    dist_we = 1'b0;
    dist_wa = tgt_r;
    dist_wd = nd_r;
    par_we = 1'b0;
    flow_we = 1'b0;
    flow_wa = a_r[AAW-1:0];
    flow_wd = alu_res[FLOW_W-1:0];
    alu_req.op = ALU_ADD;
    alu_req.a = '0;
    alu_req.b = '0;
    case (state_r)
      S_INIT_WR: begin
        ex_we = 1'b1;
        ex_wd = EXC_W'($signed(sup_q));
        pot_we = 1'b1;
        pot_wd = '0;
      end
      S_FLOW_CLR: begin
        flow_we = (m_r != '0);
        flow_wd = '0;
      end
      S_SRCH_START: begin
        dist_we = 1'b1;
        dist_wa = src_r;
        dist_wd = '0;
      end
      S_ARC_POT: begin
        pra_t = NAW'(t_q);
        pra_h = NAW'(h_q);
      end
      S_ARC_RC1: begin
        nra = tgt_r;
        alu_req.op = ALU_SUB;
        alu_req.a = ALU_W'(aw_r);
        alu_req.b = ALU_W'($signed(pt_q));
      end
      S_ARC_RC2: begin
        nra = tgt_r;
        alu_req.op = ALU_ADD;
        alu_req.a = tmp_r;
        alu_req.b = ALU_W'($signed(ph_q));
      end
      S_ARC_ND: begin
        nra = tgt_r;
        alu_req.op = dir_r ? ALU_SUB : ALU_ADD;
        alu_req.a = ALU_W'(dc_r);
        alu_req.b = tmp_r;
      end
      S_ARC_CMP: begin
        nra = tgt_r;
        alu_req.op = ALU_SUB;
        alu_req.a = ALU_W'(nd_r);
        alu_req.b = ALU_W'($signed(dist_q));
        dist_we = relax_upd;
        par_we = relax_upd;
      end
      S_POT_RD: begin
        pra_t = i_r[NAW-1:0];
      end
      S_POT_WR: begin
        alu_req.op = ALU_SUB;
        alu_req.a = ALU_W'($signed(pt_q));
        alu_req.b = ALU_W'($signed(dist_q));
        pot_we = reached_r[i_r[NAW-1:0]];
      end
      S_AUG_CHK: nra = cur_r;
      S_AUG_PAR: ara = par_q[AAW:1];
      S_AUG_ARC: begin
        alu_req.op = par_r[0] ? ALU_SUB : ALU_ADD;
        alu_req.a = ALU_W'(flow_q);
        alu_req.b = ALU_W'(scale_r);
        flow_we = 1'b1;
        flow_wa = par_r[AAW:1];
      end
      S_EX_SRC_RD: nra = src_r;
      S_EX_SRC_WR: begin
        alu_req.op = ALU_SUB;
        alu_req.a = ALU_W'($signed(ex_q));
        alu_req.b = ALU_W'(scale_r);
        ex_we = 1'b1;
        ex_wa = src_r;
      end
      S_EX_SNK_RD: nra = snk_r;
      S_EX_SNK_WR: begin
        alu_req.op = ALU_ADD;
        alu_req.a = ALU_W'($signed(ex_q));
        alu_req.b = ALU_W'(scale_r);
        ex_we = 1'b1;
        ex_wa = snk_r;
      end
      S_COST_ACC: begin
        alu_req.op = ALU_ADD;
        alu_req.a = ALU_W'(total_r);
        alu_req.b = ALU_W'(prod_r);
      end
      default: begin
      end
    endcase
  end

  assign sup_we = in_acc && (in_data.req_type == REQ_SUPPLY)
                  && (32'(in_data.item_index) < MAX_NODES);
  assign arc_we = in_acc && (in_data.req_type == REQ_ARC)
                  && (32'(in_data.item_index) < MAX_ARCS);

  csmcf_alu u_alu (.req(alu_req), .res(alu_res), .lt(alu_lt));

  csmcf_ram #(.DEPTH(MAX_NODES), .WIDTH(16)) u_sup (
    .clk, .we(sup_we), .waddr(NAW'(in_data.item_index)),
    .wdata(in_data.supply_value), .raddr(nra), .rdata(sup_q));
  csmcf_ram #(.DEPTH(MAX_NODES), .WIDTH(EXC_W)) u_exc (
    .clk, .we(ex_we), .waddr(ex_wa), .wdata(ex_wd), .raddr(nra), .rdata(ex_q));
  csmcf_ram #(.DEPTH(MAX_NODES), .WIDTH(DIST_W)) u_pot_t (
    .clk, .we(pot_we), .waddr(pot_wa), .wdata(pot_wd), .raddr(pra_t), .rdata(pt_q));
  csmcf_ram #(.DEPTH(MAX_NODES), .WIDTH(DIST_W)) u_pot_h (
    .clk, .we(pot_we), .waddr(pot_wa), .wdata(pot_wd), .raddr(pra_h), .rdata(ph_q));
  csmcf_ram #(.DEPTH(MAX_NODES), .WIDTH(DIST_W)) u_dist (
    .clk, .we(dist_we), .waddr(dist_wa), .wdata(dist_wd), .raddr(nra),
    .rdata(dist_q));
  csmcf_ram #(.DEPTH(MAX_NODES), .WIDTH(PW)) u_par (
    .clk, .we(par_we), .waddr(tgt_r), .wdata({a_r[AAW-1:0], dir_r}), .raddr(nra),
    .rdata(par_q));
  csmcf_ram #(.DEPTH(MAX_ARCS), .WIDTH(6)) u_arc_t (
    .clk, .we(arc_we), .waddr(AAW'(in_data.item_index)), .wdata(in_data.arc_tail),
    .raddr(ara), .rdata(t_q));
  csmcf_ram #(.DEPTH(MAX_ARCS), .WIDTH(6)) u_arc_h (
    .clk, .we(arc_we), .waddr(AAW'(in_data.item_index)), .wdata(in_data.arc_head),
    .raddr(ara), .rdata(h_q));
  csmcf_ram #(.DEPTH(MAX_ARCS), .WIDTH(16)) u_arc_w (
    .clk, .we(arc_we), .waddr(AAW'(in_data.item_index)),
    .wdata(in_data.arc_weight), .raddr(ara), .rdata(w_q));
  csmcf_ram #(.DEPTH(MAX_ARCS), .WIDTH(FLOW_W)) u_flow (
    .clk, .we(flow_we), .waddr(flow_wa), .wdata(flow_wd), .raddr(ara),
    .rdata(flow_q));

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      node_count_r <= 7'd1;
      arc_count_r <= 9'd0;
      scale_r <= 16'd1;
      out_valid_r <= 1'b0;
      reached_r <= '0;
      visited_r <= '0;
      pvalid_r <= '0;
    end else begin
      if (out_valid_r && !out_stall && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_NODE_COUNT: node_count_r <= cfg_wdata[6:0];
          REG_ARC_COUNT:  arc_count_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_data.req_type == REQ_SOLVE) begin
            n_r <= (32'(node_count_r) > MAX_NODES) ? NCW'(MAX_NODES)
                                                    : NCW'(node_count_r);
            m_r <= (32'(arc_count_r) > MAX_ARCS) ? ACW'(MAX_ARCS)
                                                  : ACW'(arc_count_r);
            state_r <= S_INIT;
          end
        end
        S_INIT: begin
          i_r <= '0;
          a_r <= '0;
          top_r <= '0;
          state_r <= (n_r == '0) ? S_FLOW_CLR : S_INIT_RD;
        end
        S_INIT_RD: state_r <= S_INIT_WR;
        S_INIT_WR: begin
          if (sup_abs > top_r) begin
            top_r <= sup_abs;
          end
          i_r <= i_r + NCW'(1);
          state_r <= last_node ? S_FLOW_CLR : S_INIT_RD;
        end
        S_FLOW_CLR: begin
          a_r <= a_r + ACW'(1);
          if (m_r == '0 || last_arc) begin
            state_r <= S_SCALE;
          end
        end
        S_SCALE: begin
          if (scale_r < top_r) begin
            scale_r <= {scale_r[14:0], 1'b0};
          end else begin
            state_r <= S_FIND_START;
          end
        end
        S_FIND_START: begin
          i_r <= '0;
          src_ok_r <= 1'b0;
          snk_ok_r <= 1'b0;
          state_r <= (n_r == '0) ? S_FIND_END : S_FIND_RD;
        end
        S_FIND_RD: state_r <= S_FIND_CHK;
        S_FIND_CHK: begin
          if (!src_ok_r && src_hit) begin
            src_ok_r <= 1'b1;
            src_r <= i_r[NAW-1:0];
          end
          if (!snk_ok_r && snk_hit) begin
            snk_ok_r <= 1'b1;
            snk_r <= i_r[NAW-1:0];
          end
          i_r <= i_r + NCW'(1);
          if (last_node || ((src_ok_r || src_hit) && (snk_ok_r || snk_hit))) begin
            state_r <= S_FIND_END;
          end else begin
            state_r <= S_FIND_RD;
          end
        end
        S_FIND_END: begin
          if (src_ok_r && snk_ok_r) begin
            state_r <= S_SRCH_START;
          end else if (scale_r == 16'd1) begin
            state_r <= S_COST_START;
          end else begin
            scale_r <= {1'b0, scale_r[15:1]};
            state_r <= S_FIND_START;
          end
        end
        S_SRCH_START: begin
          reached_r <= {{(MAX_NODES-1){1'b0}}, 1'b1} << src_r;
          visited_r <= '0;
          pvalid_r <= '0;
          state_r <= S_PICK_START;
        end
        S_PICK_START: begin
          i_r <= '0;
          pick_ok_r <= 1'b0;
          state_r <= S_PICK_RD;
        end
        S_PICK_RD: state_r <= S_PICK_CHK;
        S_PICK_CHK: begin
          if (!visited_r[i_r[NAW-1:0]] && reached_r[i_r[NAW-1:0]]
              && (!pick_ok_r || $signed(dist_q) < best_r)) begin
            pick_ok_r <= 1'b1;
            pick_r <= i_r[NAW-1:0];
            best_r <= $signed(dist_q);
          end
          i_r <= i_r + NCW'(1);
          state_r <= last_node ? S_PICK_END : S_PICK_RD;
        end
        S_PICK_END: begin
          if (pick_ok_r) begin
            visited_r[pick_r] <= 1'b1;
            dc_r <= best_r;
            a_r <= '0;
            state_r <= (m_r == '0) ? S_PICK_START : S_ARC_RD;
          end else begin
            state_r <= S_SRCH_END;
          end
        end
        S_ARC_RD: state_r <= S_ARC_POT;
        S_ARC_POT: begin
          at_r <= t_q;
          ah_r <= h_q;
          aw_r <= w_q;
          af_r <= flow_q;
          state_r <= S_ARC_CHK;
        end
        S_ARC_CHK: begin
          dir_r <= rev;
          tgt_r <= rev ? NAW'(at_r) : NAW'(ah_r);
          if (fwd || rev) begin
            state_r <= S_ARC_RC1;
          end else begin
            a_r <= a_r + ACW'(1);
            state_r <= last_arc ? S_PICK_START : S_ARC_RD;
          end
        end
        S_ARC_RC1: begin
          tmp_r <= alu_res;
          state_r <= S_ARC_RC2;
        end
        S_ARC_RC2: begin
          tmp_r <= alu_res;
          state_r <= S_ARC_ND;
        end
        S_ARC_ND: begin
          nd_r <= alu_res[DIST_W-1:0];
          state_r <= S_ARC_CMP;
        end
        S_ARC_CMP: begin
          if (relax_upd) begin
            reached_r[tgt_r] <= 1'b1;
            pvalid_r[tgt_r] <= 1'b1;
          end
          a_r <= a_r + ACW'(1);
          state_r <= last_arc ? S_PICK_START : S_ARC_RD;
        end
        S_SRCH_END: begin
          if (!reached_r[snk_r]) begin
            feas_r <= 1'b0;
            total_r <= '0;
            scale_r <= 16'd1;
            state_r <= S_DONE;
          end else begin
            i_r <= '0;
            state_r <= S_POT_RD;
          end
        end
        S_POT_RD: state_r <= S_POT_WR;
        S_POT_WR: begin
          i_r <= i_r + NCW'(1);
          if (last_node) begin
            cur_r <= snk_r;
            steps_r <= '0;
            state_r <= S_AUG_CHK;
          end else begin
            state_r <= S_POT_RD;
          end
        end
        S_AUG_CHK: begin
          if (cur_r != src_r && steps_r < n_r && pvalid_r[cur_r]) begin
            state_r <= S_AUG_PAR;
          end else begin
            state_r <= S_EX_SRC_RD;
          end
        end
        S_AUG_PAR: begin
          par_r <= par_q;
          state_r <= S_AUG_ARC;
        end
        S_AUG_ARC: begin
          cur_r <= par_r[0] ? NAW'(h_q) : NAW'(t_q);
          steps_r <= steps_r + NCW'(1);
          state_r <= S_AUG_CHK;
        end
        S_EX_SRC_RD: state_r <= S_EX_SRC_WR;
        S_EX_SRC_WR: state_r <= S_EX_SNK_RD;
        S_EX_SNK_RD: state_r <= S_EX_SNK_WR;
        S_EX_SNK_WR: state_r <= S_FIND_START;
        S_COST_START: begin
          a_r <= '0;
          total_r <= '0;
          feas_r <= 1'b1;
          scale_r <= 16'd1;
          state_r <= (m_r == '0) ? S_DONE : S_COST_RD;
        end
        S_COST_RD: state_r <= S_COST_MUL;
        S_COST_MUL: begin
          prod_r <= 40'(flow_q) * 40'(w_q);
          state_r <= S_COST_ACC;
        end
        S_COST_ACC: begin
          total_r <= (cost_sum > ALU_W'(COST_MAX)) ? COST_MAX
                                                    : cost_sum[COST_W-1:0];
          a_r <= a_r + ACW'(1);
          state_r <= last_arc ? S_DONE : S_COST_RD;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_res_r.feasible <= feas_r;
            out_res_r.total_cost <= total_r;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `CSMCF_ASSERT_NOW(a_src_snk_differ, state_r == S_SRCH_START, src_r != snk_r, "source equals sink")
  `CSMCF_ASSERT_NOW(a_scale_idle, state_r == S_IDLE, scale_r == 16'd1, "scale not one at idle")
  `CSMCF_ASSERT_NOW(a_pick_fresh, state_r == S_PICK_END && pick_ok_r, !visited_r[pick_r], "picked node already settled")
  `CSMCF_ASSERT_NEXT(a_done_out, state_r == S_DONE && !out_valid_r, out_valid_r && state_r == S_IDLE, "result not registered")

endmodule
